FILE: rtl/ttqc_pkg.sv
// Package: codes, field layout and state type of the ticket queue with credit capacity.
`default_nettype none

package ttqc_pkg;

   // Input item kinds (carried on req_tuser)
   localparam logic [2:0] KIND_ADD     = 3'd0;
   localparam logic [2:0] KIND_REMOVE  = 3'd1;
   localparam logic [2:0] KIND_LOOKUP  = 3'd2;
   localparam logic [2:0] KIND_SET_CAP = 3'd3;
   localparam logic [2:0] KIND_NEXT    = 3'd4;
   localparam logic [2:0] KIND_VOTED   = 3'd5;
   localparam logic [2:0] KIND_MISSED  = 3'd6;

   // Result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_NONE = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // Configuration register indexes
   localparam logic CSR_VOTES_TO_GROW    = 1'b0;
   localparam logic CSR_MISSES_TO_SHRINK = 1'b1;

   // Fixed field widths
   localparam int KIND_W   = 3;
   localparam int FIELD_W  = 64;
   localparam int HEIGHT_W = 64;
   localparam int CAP_W    = 16;
   localparam int STATUS_W = 2;

   // Request tdata layout
   localparam int REQ_KEY_LSB    = 0;
   localparam int REQ_HEIGHT_LSB = 64;
   localparam int REQ_MATURE_LSB = 128;
   localparam int REQ_NEWCAP_LSB = 192;
   localparam int REQ_DATA_W     = 208;

   // Response tdata layout
   localparam int RSP_PAD_W  = 6;
   localparam int RSP_DATA_W = 152;

   // Saturation limits
   localparam logic [CAP_W-1:0] CAP_MAX    = 16'hFFFF;
   localparam logic [CAP_W-1:0] STREAK_MAX = 16'hFFFF;

   // Sequencer states, one-hot
   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_SHIFT = 5'b00100,
      ST_NEXT  = 5'b01000,
      ST_RESP  = 5'b10000
   } state_type;

endpackage

`default_nettype wire

FILE: rtl/ttqc_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
`default_nettype none

module ttqc_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write, and register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

FILE: rtl/ticket_queue_with_credit_capacity.sv
// Top level: ordered ticket list in RAM with search, compaction and credit capacity.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+------------------------------------------------
//  req     | in  | req_tvalid/req_tready | tuser kind; tdata key, height, mature, new cap
//  rsp     | out | rsp_tvalid/rsp_tready | tdata status, key, height, capacity now
//  csr     | in  | csr_wen               | csr_index, csr_data (write only)
//
// One item at a time. Add, set capacity, voted and missed go straight to the response
// state; next first reads the entry at the read position when it lies below both the
// count and the capacity. Lookup and remove walk the RAM one entry per cycle through its
// single read port, and remove then moves the tail down one slot. Reset is synchronous;
// the RAM needs no clearing since only entries below the count are ever read. A stalled
// rsp holds the finished result in the response stage and the next beat waits.
`default_nettype none

module ticket_queue_with_credit_capacity #(
   parameter int DEPTH     = 64,
   parameter int KEY_WIDTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [2:0]   req_tuser,    // [2:0] kind
   input  wire logic [207:0] req_tdata,    // [63:0] ticket_key, [127:64] ticket_height,
                                           // [191:128] mature_height, [207:192] new_capacity
   // response channel
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic      [151:0] rsp_tdata,    // [1:0] status, [65:2] out_key,
                                           // [129:66] out_height, [145:130] capacity_now,
                                           // [151:146] zero
   // configuration port
   input  wire logic         csr_wen,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_data
);

   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(DEPTH + 1);
   localparam int EW    = KEY_WIDTH + ttqc_pkg::HEIGHT_W;
   localparam int CMP_W = (CW > ttqc_pkg::CAP_W) ? CW : ttqc_pkg::CAP_W;
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

   // control state
   ttqc_pkg::state_type state_ff, state_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [CW-1:0]  pos_ff, pos_in;
   logic [CW-1:0]  idx_ff, idx_in;
   logic [15:0]    cap_ff, cap_in;
   logic [15:0]    vote_ff, vote_in;
   logic [15:0]    miss_ff, miss_in;
   logic [15:0]    grow_thr_ff;
   logic [15:0]    shrink_thr_ff;
   logic           rsp_valid_ff, rsp_valid_in;

   // item and result payload
   logic [2:0]            kind_ff, kind_in;
   logic [KEY_WIDTH-1:0]  key_ff, key_in;
   logic [63:0]           mature_ff, mature_in;
   logic [1:0]            res_status_ff, res_status_in;
   logic [KEY_WIDTH-1:0]  res_key_ff, res_key_in;
   logic [63:0]           res_height_ff, res_height_in;
   logic [151:0]          rsp_data_ff, rsp_data_in;

   // RAM port signals
   logic           wr_en;
   logic [AW-1:0]  wr_addr;
   logic [EW-1:0]  wr_data;
   logic [AW-1:0]  rd_addr;
   logic [EW-1:0]  rd_data;

   // request field views
   logic                 req_fire;
   logic [KEY_WIDTH-1:0] req_key;
   logic [63:0]          req_height;
   logic [63:0]          req_mature;
   logic [15:0]          req_newcap;
   logic [KEY_WIDTH-1:0] rd_key;
   logic [63:0]          rd_height;
   logic [15:0]          vote_inc;
   logic [15:0]          miss_inc;
   logic                 next_ok;
   logic [CW-1:0]        idx_plus1;
   logic [CW-1:0]        idx_plus2;

   assign req_tready = (state_ff == ttqc_pkg::ST_IDLE);
   assign req_fire   = req_tvalid & req_tready;
   assign req_key    = req_tdata[ttqc_pkg::REQ_KEY_LSB +: KEY_WIDTH];
   assign req_height = req_tdata[ttqc_pkg::REQ_HEIGHT_LSB +: 64];
   assign req_mature = req_tdata[ttqc_pkg::REQ_MATURE_LSB +: 64];
   assign req_newcap = req_tdata[ttqc_pkg::REQ_NEWCAP_LSB +: 16];

   assign rd_key    = rd_data[ttqc_pkg::HEIGHT_W +: KEY_WIDTH];
   assign rd_height = rd_data[ttqc_pkg::HEIGHT_W-1:0];

   assign vote_inc  = (vote_ff == ttqc_pkg::STREAK_MAX) ? vote_ff : vote_ff + 16'd1;
   assign miss_inc  = (miss_ff == ttqc_pkg::STREAK_MAX) ? miss_ff : miss_ff + 16'd1;
   assign idx_plus1 = idx_ff + CW'(1);
   assign idx_plus2 = idx_ff + CW'(2);

   // a ticket lies below both the count and the capacity at the read position
   assign next_ok = (pos_ff < count_ff) && (CMP_W'(pos_ff) < CMP_W'(cap_ff));

   // ticket store: key over height, one entry per slot
   ttqc_ram #(
      .WIDTH (EW),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // sequencer: decode on accept, walk the store, then hand the beat to the response stage
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      idx_in        = idx_ff;
      cap_in        = cap_ff;
      vote_in       = vote_ff;
      miss_in       = miss_ff;
      kind_in       = kind_ff;
      key_in        = key_ff;
      mature_in     = mature_ff;
      res_status_in = res_status_ff;
      res_key_in    = res_key_ff;
      res_height_in = res_height_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = count_ff[AW-1:0];
      wr_data       = {req_key, req_height};
      rd_addr       = idx_plus1[AW-1:0];

      case (state_ff)
         ttqc_pkg::ST_IDLE: begin
            rd_addr = '0;
            if (req_fire) begin
               kind_in       = req_tuser;
               key_in        = req_key;
               mature_in     = req_mature;
               res_status_in = ttqc_pkg::STATUS_OK;
               res_key_in    = '0;
               res_height_in = '0;
               idx_in        = '0;
               state_in      = ttqc_pkg::ST_RESP;
               case (req_tuser)
                  ttqc_pkg::KIND_ADD: begin
                     if (count_ff == DEPTH_C) begin
                        res_status_in = ttqc_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ttqc_pkg::KIND_REMOVE, ttqc_pkg::KIND_LOOKUP: begin
                     if (count_ff == '0) begin
                        res_status_in = ttqc_pkg::STATUS_NONE;
                     end else begin
                        state_in = ttqc_pkg::ST_SCAN;
                     end
                  end
                  ttqc_pkg::KIND_SET_CAP: begin
                     cap_in = req_newcap;
                  end
                  ttqc_pkg::KIND_NEXT: begin
                     rd_addr = pos_ff[AW-1:0];
                     if (next_ok) begin
                        state_in = ttqc_pkg::ST_NEXT;
                     end else begin
                        res_status_in = ttqc_pkg::STATUS_NONE;
                     end
                  end
                  ttqc_pkg::KIND_VOTED: begin
                     miss_in = '0;
                     vote_in = vote_inc;
                     if (vote_inc >= grow_thr_ff) begin
                        vote_in = '0;
                        if (cap_ff != ttqc_pkg::CAP_MAX) begin
                           cap_in = cap_ff + 16'd1;
                        end
                     end
                  end
                  ttqc_pkg::KIND_MISSED: begin
                     vote_in = '0;
                     miss_in = miss_inc;
                     if (miss_inc >= shrink_thr_ff) begin
                        miss_in = '0;
                        cap_in  = cap_ff >> 1;
                     end
                  end
                  default: begin
                     res_status_in = ttqc_pkg::STATUS_NONE;
                  end
               endcase
            end
         end

         // entry idx is on the read port; prefetch idx + 1
         ttqc_pkg::ST_SCAN: begin
            rd_addr = idx_plus1[AW-1:0];
            if (rd_key == key_ff) begin
               if (kind_ff == ttqc_pkg::KIND_LOOKUP) begin
                  res_key_in    = rd_key;
                  res_height_in = rd_height;
                  state_in      = ttqc_pkg::ST_RESP;
               end else if (idx_plus1 >= count_ff) begin
                  count_in = count_ff - CW'(1);
                  state_in = ttqc_pkg::ST_RESP;
               end else begin
                  state_in = ttqc_pkg::ST_SHIFT;
               end
            end else if (idx_plus1 >= count_ff) begin
               res_status_in = ttqc_pkg::STATUS_NONE;
               state_in      = ttqc_pkg::ST_RESP;
            end else begin
               idx_in = idx_plus1;
            end
         end

         // move entry idx + 1 down to idx, prefetch idx + 2
         ttqc_pkg::ST_SHIFT: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff[AW-1:0];
            wr_data = rd_data;
            rd_addr = idx_plus2[AW-1:0];
            if (idx_plus2 >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ttqc_pkg::ST_RESP;
            end else begin
               idx_in = idx_plus1;
            end
         end

         // entry at the read position is on the read port
         ttqc_pkg::ST_NEXT: begin
            rd_addr  = pos_ff[AW-1:0];
            state_in = ttqc_pkg::ST_RESP;
            if (rd_height <= mature_ff) begin
               res_key_in    = rd_key;
               res_height_in = rd_height;
               pos_in        = pos_ff + CW'(1);
            end else begin
               res_status_in = ttqc_pkg::STATUS_NONE;
            end
         end

         // load the response stage once it is free
         ttqc_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{ttqc_pkg::RSP_PAD_W{1'b0}}, cap_ff, res_height_ff,
                               ttqc_pkg::FIELD_W'(res_key_ff), res_status_ff};
               state_in     = ttqc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ttqc_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ttqc_pkg::ST_IDLE;
         count_ff      <= '0;
         pos_ff        <= '0;
         cap_ff        <= '0;
         vote_ff       <= '0;
         miss_ff       <= '0;
         rsp_valid_ff  <= 1'b0;
         grow_thr_ff   <= 16'd4;
         shrink_thr_ff <= 16'd4;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         cap_ff       <= cap_in;
         vote_ff      <= vote_in;
         miss_ff      <= miss_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wen) begin
            case (csr_index)
               ttqc_pkg::CSR_VOTES_TO_GROW:    grow_thr_ff   <= csr_data;
               ttqc_pkg::CSR_MISSES_TO_SHRINK: shrink_thr_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      kind_ff       <= kind_in;
      key_ff        <= key_in;
      mature_ff     <= mature_in;
      res_status_ff <= res_status_in;
      res_key_ff    <= res_key_in;
      res_height_ff <= res_height_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // the list never holds more than DEPTH tickets
   assert property (@(posedge clock) disable iff (reset) count_ff <= DEPTH_C)
      else $error("ticket count above depth");

   // an accepted add to a list with room grows the count by one
   assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_tuser == ttqc_pkg::KIND_ADD && count_ff != DEPTH_C)
      |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("add did not grow the count");

   // a new beat appears only out of the response state
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff && !rsp_tready))
      |-> ($past(state_ff) == ttqc_pkg::ST_RESP))
      else $error("response loaded outside response state");

   // compaction only writes slots below the last ticket
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ttqc_pkg::ST_SHIFT) |-> (idx_plus1 < count_ff))
      else $error("shift beyond end of list");

endmodule

`default_nettype wire

FILE: sim/ticket_queue_checker.sv
// Checker: watches the ticket queue channels, predicts every result beat and compares it.
`default_nettype none

module ticket_queue_checker #(
   parameter int DEPTH = 64
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   input  wire logic         req_tready,
   input  wire logic [2:0]   req_tuser,    // [2:0] kind
   input  wire logic [207:0] req_tdata,    // [63:0] ticket_key, [127:64] ticket_height,
                                           // [191:128] mature_height, [207:192] new_capacity
   input  wire logic         rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic [151:0] rsp_tdata,    // [1:0] status, [65:2] out_key,
                                           // [129:66] out_height, [145:130] capacity_now
   input  wire logic         csr_wen,
   input  wire logic         csr_index,
   input  wire logic [15:0]  csr_data,
   output int                fail_count,
   output int                outstanding
);

   typedef struct packed {
      logic [ttqc_pkg::STATUS_W-1:0] status;
      logic [63:0]                   key;
      logic [63:0]                   height;
      logic [ttqc_pkg::CAP_W-1:0]    capacity;
   } ticket_result_type;

   // Shadow copy of the ticket list and the credit state
   logic [63:0]                stored_keys    [DEPTH];
   logic [63:0]                stored_heights [DEPTH];
   int unsigned                ticket_count;
   int unsigned                read_pos;
   logic [ttqc_pkg::CAP_W-1:0] credit;
   logic [15:0]                vote_run;
   logic [15:0]                miss_run;
   logic [15:0]                grow_after;
   logic [15:0]                shrink_after;

   ticket_result_type awaited_results [$];
   int                errors;

   // Apply one request to the shadow state and return the result it must produce
   function automatic ticket_result_type predict_ticket(input logic [2:0] kind,
                                                        input logic [63:0] key,
                                                        input logic [63:0] height,
                                                        input logic [63:0] mature,
                                                        input logic [15:0] new_cap);
      ticket_result_type r;
      int unsigned       hit;
      int unsigned       limit;
      r = '0;
      r.status = ttqc_pkg::STATUS_OK;
      // locate the first ticket with this key
      hit = ticket_count;
      for (int i = 0; i < ticket_count; i++) begin
         if (hit == ticket_count && stored_keys[i] == key) hit = i;
      end
      case (kind)
         ttqc_pkg::KIND_ADD: begin
            if (ticket_count >= DEPTH) begin
               r.status = ttqc_pkg::STATUS_FULL;
            end else begin
               stored_keys[ticket_count]    = key;
               stored_heights[ticket_count] = height;
               ticket_count++;
            end
         end
         ttqc_pkg::KIND_REMOVE: begin
            if (hit < ticket_count) begin
               // close the gap, leave the read position alone
               for (int i = hit; i + 1 < ticket_count; i++) begin
                  stored_keys[i]    = stored_keys[i+1];
                  stored_heights[i] = stored_heights[i+1];
               end
               ticket_count--;
            end else begin
               r.status = ttqc_pkg::STATUS_NONE;
            end
         end
         ttqc_pkg::KIND_LOOKUP: begin
            if (hit < ticket_count) begin
               r.key    = stored_keys[hit];
               r.height = stored_heights[hit];
            end else begin
               r.status = ttqc_pkg::STATUS_NONE;
            end
         end
         ttqc_pkg::KIND_SET_CAP: begin
            credit = new_cap;
         end
         ttqc_pkg::KIND_NEXT: begin
            limit = (ticket_count < credit) ? ticket_count : credit;
            if (read_pos < limit && read_pos < DEPTH &&
                stored_heights[read_pos] <= mature) begin
               r.key    = stored_keys[read_pos];
               r.height = stored_heights[read_pos];
               read_pos++;
            end else begin
               r.status = ttqc_pkg::STATUS_NONE;
            end
         end
         ttqc_pkg::KIND_VOTED: begin
            miss_run = '0;
            if (vote_run != ttqc_pkg::STREAK_MAX) vote_run++;
            if (vote_run >= grow_after) begin
               if (credit != ttqc_pkg::CAP_MAX) credit++;
               vote_run = '0;
            end
         end
         ttqc_pkg::KIND_MISSED: begin
            vote_run = '0;
            if (miss_run != ttqc_pkg::STREAK_MAX) miss_run++;
            if (miss_run >= shrink_after) begin
               credit   = credit >> 1;
               miss_run = '0;
            end
         end
         default: begin
            r.status = ttqc_pkg::STATUS_NONE;
         end
      endcase
      r.capacity = credit;
      return r;
   endfunction

   // Track register writes, predict on request beats, compare on result beats
   always @(posedge clock) begin
      ticket_result_type want;
      ticket_result_type got;
      if (reset) begin
         ticket_count = 0;
         read_pos     = 0;
         credit       = '0;
         vote_run     = '0;
         miss_run     = '0;
         grow_after   = 16'd4;
         shrink_after = 16'd4;
         errors       = 0;
         awaited_results.delete();
      end else begin
         if (csr_wen) begin
            if (csr_index == ttqc_pkg::CSR_VOTES_TO_GROW) grow_after = csr_data;
            else shrink_after = csr_data;
         end
         if (req_tvalid && req_tready) begin
            awaited_results.push_back(predict_ticket(
               req_tuser,
               req_tdata[ttqc_pkg::REQ_KEY_LSB +: ttqc_pkg::FIELD_W],
               req_tdata[ttqc_pkg::REQ_HEIGHT_LSB +: ttqc_pkg::HEIGHT_W],
               req_tdata[ttqc_pkg::REQ_MATURE_LSB +: ttqc_pkg::HEIGHT_W],
               req_tdata[ttqc_pkg::REQ_NEWCAP_LSB +: ttqc_pkg::CAP_W]));
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status   = rsp_tdata[1:0];
            got.key      = rsp_tdata[65:2];
            got.height   = rsp_tdata[129:66];
            got.capacity = rsp_tdata[145:130];
            if (awaited_results.size() == 0) begin
               if (errors < 10) $display("result beat with no request pending: tdata %h", rsp_tdata);
               errors++;
            end else begin
               want = awaited_results.pop_front();
               if (got.status !== want.status || got.key !== want.key ||
                   got.height !== want.height || got.capacity !== want.capacity ||
                   rsp_tdata[151:146] !== '0) begin
                  if (errors < 10) begin
                     $display("mismatch: expected status %0d key %h height %h capacity %0d",
                              want.status, want.key, want.height, want.capacity);
                     $display("          got      status %0d key %h height %h capacity %0d pad %h",
                              got.status, got.key, got.height, got.capacity, rsp_tdata[151:146]);
                  end
                  errors++;
               end
            end
         end
      end
      outstanding <= awaited_results.size();
      fail_count  <= errors;
   end

endmodule

`default_nettype wire

FILE: sim/ticket_queue_with_credit_capacity_tb.sv
// Testbench top: drives requests, register writes and backpressure into the ticket queue.
`default_nettype none

module ticket_queue_with_credit_capacity_tb;

   localparam int          CYCLE_LIMIT    = 2_000_000;
   localparam int          PHASE_ITEMS    = 190;
   localparam int          BURST_ITEMS    = 20;
   localparam logic [2:0]  KIND_UNKNOWN   = 3'd7;
   localparam logic [63:0] ALL_ONES       = '1;

   typedef enum int {MIX_BALANCED, MIX_FILL, MIX_DRAIN} item_mix_type;

   logic         clock       = 1'b0;
   logic         reset       = 1'b1;
   logic         req_tvalid  = 1'b0;
   logic [2:0]   req_tuser   = '0;
   logic [207:0] req_tdata   = '0;
   logic         rsp_tready  = 1'b0;
   logic         csr_wen     = 1'b0;
   logic         csr_index   = 1'b0;
   logic [15:0]  csr_data    = '0;
   wire          req_tready;
   wire          rsp_tvalid;
   wire  [151:0] rsp_tdata;

   int           fail_count;
   int           outstanding;
   int           send_idle_pct  = 0;
   int           recv_stall_pct = 0;
   int unsigned  cycle_count    = 0;

   ticket_queue_with_credit_capacity uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ticket_queue_checker ticket_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fail_count  (fail_count),
      .outstanding (outstanding)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Stall the result channel at the current rate
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Present one request beat, idling first at the sender rate, and hold until accepted
   task automatic send_ticket_item(input logic [2:0] kind, input logic [63:0] key,
                                   input logic [63:0] height, input logic [63:0] mature,
                                   input logic [15:0] new_cap);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {new_cap, mature, height, key};
      do @(posedge clock); while (!req_tready);
   endtask

   // Write one register, then drop the write enable again before the next write
   task automatic write_register(input logic index, input logic [15:0] value);
      csr_wen   <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      csr_wen   <= 1'b0;
      @(posedge clock);
   endtask

   // Drop valid and wait until every predicted result beat has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
   endtask

   // Build one random request; small key pool so removes and lookups hit
   task automatic send_random_item(input item_mix_type mix);
      int unsigned roll;
      logic [2:0]  kind;
      logic [63:0] key;
      logic [63:0] height;
      logic [63:0] mature;
      logic [15:0] new_cap;
      roll = $urandom_range(99);
      case (mix)
         MIX_FILL:
            kind = roll < 70 ? ttqc_pkg::KIND_ADD : roll < 80 ? ttqc_pkg::KIND_NEXT :
                   roll < 88 ? ttqc_pkg::KIND_LOOKUP : ttqc_pkg::KIND_VOTED;
         MIX_DRAIN:
            kind = roll < 55 ? ttqc_pkg::KIND_REMOVE : roll < 70 ? ttqc_pkg::KIND_LOOKUP :
                   roll < 85 ? ttqc_pkg::KIND_NEXT : ttqc_pkg::KIND_MISSED;
         default:
            kind = roll < 24 ? ttqc_pkg::KIND_ADD : roll < 40 ? ttqc_pkg::KIND_REMOVE :
                   roll < 54 ? ttqc_pkg::KIND_LOOKUP : roll < 68 ? ttqc_pkg::KIND_NEXT :
                   roll < 74 ? ttqc_pkg::KIND_SET_CAP : roll < 86 ? ttqc_pkg::KIND_VOTED :
                   roll < 97 ? ttqc_pkg::KIND_MISSED : KIND_UNKNOWN;
      endcase
      roll = $urandom_range(99);
      key = roll < 15 ? {$urandom, $urandom} : roll < 20 ? ALL_ONES :
            64'($urandom_range(15));
      roll = $urandom_range(99);
      height = roll < 50 ? 64'($urandom_range(200)) : roll < 60 ? {$urandom, $urandom} :
               roll < 65 ? ALL_ONES : 64'($urandom_range(1000));
      roll = $urandom_range(99);
      mature = roll < 60 ? 64'($urandom_range(400)) : roll < 75 ? {$urandom, $urandom} :
               roll < 85 ? ALL_ONES : '0;
      roll = $urandom_range(99);
      new_cap = roll < 70 ? 16'($urandom_range(80)) : roll < 80 ? ttqc_pkg::CAP_MAX :
                roll < 85 ? 16'd0 : 16'($urandom);
      send_ticket_item(kind, key, height, mature, new_cap);
   endtask

   initial begin
      item_mix_type mix;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, unknown kind, extremes, capacity saturation and halving
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, ALL_ONES, '0);
      send_ticket_item(ttqc_pkg::KIND_LOOKUP,  64'd5, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_REMOVE,  64'd5, '0, '0, '0);
      send_ticket_item(KIND_UNKNOWN, ALL_ONES, ALL_ONES, ALL_ONES, ttqc_pkg::CAP_MAX);
      send_ticket_item(ttqc_pkg::KIND_ADD,     '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_ADD,     ALL_ONES, ALL_ONES, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_ADD,     64'h0123_4567_89ab_cdef, 64'd50, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, ALL_ONES, '0);
      send_ticket_item(ttqc_pkg::KIND_SET_CAP, '0, '0, '0, ttqc_pkg::CAP_MAX);
      repeat (4) send_ticket_item(ttqc_pkg::KIND_VOTED, '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, ALL_ONES, '0);
      send_ticket_item(ttqc_pkg::KIND_LOOKUP,  ALL_ONES, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_REMOVE,  '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, ALL_ONES, '0);
      send_ticket_item(ttqc_pkg::KIND_ADD,     64'h5555_aaaa_5555_aaaa, 64'd7, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_NEXT,    '0, '0, 64'd7, '0);
      // a vote in the middle resets the miss run
      send_ticket_item(ttqc_pkg::KIND_MISSED,  '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_MISSED,  '0, '0, '0, '0);
      send_ticket_item(ttqc_pkg::KIND_VOTED,   '0, '0, '0, '0);
      repeat (4) send_ticket_item(ttqc_pkg::KIND_MISSED, '0, '0, '0, '0);
      drain_results();

      // Random phases, each with its own thresholds and idling
      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: begin
               write_register(ttqc_pkg::CSR_VOTES_TO_GROW, 16'd0);
               write_register(ttqc_pkg::CSR_MISSES_TO_SHRINK, 16'd0);
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
            1: begin
               write_register(ttqc_pkg::CSR_VOTES_TO_GROW, 16'd1);
               write_register(ttqc_pkg::CSR_MISSES_TO_SHRINK, 16'd2);
               send_idle_pct  <= 85;
               recv_stall_pct <= 0;
            end
            2: begin
               write_register(ttqc_pkg::CSR_VOTES_TO_GROW, 16'hffff);
               write_register(ttqc_pkg::CSR_MISSES_TO_SHRINK, 16'hffff);
               send_idle_pct  <= 0;
               recv_stall_pct <= 85;
            end
            3: begin
               write_register(ttqc_pkg::CSR_VOTES_TO_GROW, 16'd2);
               write_register(ttqc_pkg::CSR_MISSES_TO_SHRINK, 16'd1);
               send_idle_pct  <= 33;
               recv_stall_pct <= 33;
            end
            default: begin
               write_register(ttqc_pkg::CSR_VOTES_TO_GROW, 16'($urandom_range(3, 8)));
               write_register(ttqc_pkg::CSR_MISSES_TO_SHRINK, 16'($urandom_range(3, 8)));
               send_idle_pct  <= 0;
               recv_stall_pct <= 0;
            end
         endcase
         // pick a mix per burst so the list both fills up and empties out
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (n % BURST_ITEMS == 0) begin
               case ($urandom_range(3))
                  0:       mix = MIX_FILL;
                  1:       mix = MIX_DRAIN;
                  default: mix = MIX_BALANCED;
               endcase
            end
            send_random_item(mix);
         end
         drain_results();
      end

      repeat (20) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

FILE: ticket_queue_with_credit_capacity.f
rtl/ttqc_pkg.sv
rtl/ttqc_ram.sv
rtl/ticket_queue_with_credit_capacity.sv
sim/ticket_queue_checker.sv
sim/ticket_queue_with_credit_capacity_tb.sv
